// ===== sv/pai_pkg.sv =====
// Package for particle_attract_integrate: payload types, constants, helpers.
// No dependencies; used by the interface file and every module.
package pai_pkg;

  localparam int unsigned QW = 24;
  localparam int unsigned DW = 25;      // difference width
  localparam int unsigned SQW = 50;     // squared length width
  localparam int unsigned RW = 25;      // sqrt result width
  localparam int unsigned DENW = 26;    // length + epsilon
  localparam int unsigned NUMW = 37;    // |diff| * gain
  localparam int unsigned DTW = 10;
  localparam logic [6:0]  Q_EPS = 7'd66;
  localparam logic [11:0] Q_GAIN = 12'd3277;
  localparam logic [9:0]  MS_PER_S = 10'd1000;
  localparam logic signed [QW-1:0] V_MAX = 24'sh7FFFFF;
  localparam logic signed [QW-1:0] V_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [QW-1:0] pos_x;
    logic signed [QW-1:0] pos_y;
    logic signed [QW-1:0] vel_x;
    logic signed [QW-1:0] vel_y;
    logic signed [QW-1:0] target_x;
    logic signed [QW-1:0] target_y;
    logic                 apply_impulse;
    logic [DTW-1:0]       dt_ms;
    logic                 last_particle;
  } pai_in_t;

  typedef struct packed {
    logic signed [QW-1:0] new_pos_x;
    logic signed [QW-1:0] new_pos_y;
    logic signed [QW-1:0] new_vel_x;
    logic signed [QW-1:0] new_vel_y;
    logic                 frame_done;
  } pai_out_t;

  function automatic logic signed [QW-1:0] sat24(input logic signed [35:0] v);
    if (v > 36'sd8388607) return V_MAX;
    if (v < -36'sd8388608) return V_MIN;
    return v[QW-1:0];
  endfunction

endpackage

// ===== sv/pai_if.sv =====
// Valid/ready channel interfaces for particle_attract_integrate.
// Depends on pai_pkg.
interface pai_in_if;
  import pai_pkg::*;
  logic    valid;
  logic    ready;
  pai_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pai_out_if;
  import pai_pkg::*;
  logic     valid;
  logic     ready;
  pai_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/particle_attract_integrate_core.sv =====
// Top level of particle_attract_integrate: impulse and Euler step pipeline.
// Depends on pai_pkg, pai_if, pai_sqrt, pai_div.
//
// Usage: one particle enters per transaction on in_ch (valid/ready); one
// result leaves per transaction on out_ch, in input order.
// Throughput: one transaction per cycle while out_ch is not stalled.
// Pipeline: the differences register at the accepting edge, then come the
// squares, the bit-per-stage square root, the numerators, the bit-per-stage
// divider, the velocity add, the dt product, the reciprocal multiply by
// 1/1000, and correction, position add and output register together.
// The long pipeline is set by the divider stage count.
// Stall: the whole pipeline holds when the output register is full and not
// taken; in_ch.ready is low only then. Nothing is lost or repeated.
// Reset (rst, synchronous): clears every valid bit; payload is not reset.
// Fixed point is Q7.16 with saturation on velocity and position.
// Items without the impulse flag pass the same stages with a zero impulse.
module particle_attract_integrate_core (
  input logic     clk,
  input logic     rst,
  pai_in_if.sink  in_ch,
  pai_out_if.source out_ch
);
  import pai_pkg::*;

  // Sideband carried down the long units.
  typedef struct packed {
    pai_in_t              it;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } side_t;
  localparam int unsigned SIDEW = $bits(side_t);

  // Hold everything while the result waits.
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: differences.
  logic  a_v;
  side_t a_s;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_ch.valid && in_ch.ready;
    if (en) begin
      a_s.it <= in_ch.data;
      a_s.dx <= DW'(in_ch.data.target_x) - DW'(in_ch.data.pos_x);
      a_s.dy <= DW'(in_ch.data.target_y) - DW'(in_ch.data.pos_y);
    end
  end

  // Stage B: squares and sum (each square a 25x25 product).
  logic             b_v;
  side_t            b_s;
  logic [SQW-1:0]   b_sq;
  logic [DW-1:0]    ax, ay;
  assign ax = a_s.dx[DW-1] ? DW'(-a_s.dx) : a_s.dx;
  assign ay = a_s.dy[DW-1] ? DW'(-a_s.dy) : a_s.dy;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
    if (en) begin
      b_s <= a_s;
      b_sq <= SQW'(ax) * SQW'(ax) + SQW'(ay) * SQW'(ay);
    end
  end

  // Length by pipelined square root.
  logic           r_v;
  logic [RW-1:0]  r_root;
  logic [SIDEW-1:0] r_side;
  pai_sqrt #(.SW(SIDEW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(b_v), .in_rad(b_sq), .in_side(b_s),
    .out_valid(r_v), .out_root(r_root), .out_side(r_side)
  );
  side_t r_s;
  assign r_s = side_t'(r_side);

  // Stage C: numerators and denominator.
  logic             c_v;
  side_t            c_s;
  logic [NUMW-1:0]  c_nx, c_ny;
  logic [DENW-1:0]  c_den;
  logic [DW-1:0]    rax, ray;
  assign rax = r_s.dx[DW-1] ? DW'(-r_s.dx) : r_s.dx;
  assign ray = r_s.dy[DW-1] ? DW'(-r_s.dy) : r_s.dy;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= r_v;
    if (en) begin
      c_s <= r_s;
      c_nx <= NUMW'(rax) * NUMW'(Q_GAIN);
      c_ny <= NUMW'(ray) * NUMW'(Q_GAIN);
      c_den <= DENW'(r_root) + DENW'(Q_EPS);
    end
  end

  // Two dividers in lockstep; y carries the sideband.
  logic             qx_v, qy_v;
  logic [NUMW-1:0]  qx, qy;
  logic [0:0]       qx_side;
  logic [SIDEW-1:0] qy_side;
  pai_div #(.NW(NUMW), .DNW(DENW), .SW(1)) u_divx (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_v), .in_num(c_nx), .in_den(c_den), .in_side(1'b0),
    .out_valid(qx_v), .out_quo(qx), .out_side(qx_side)
  );
  pai_div #(.NW(NUMW), .DNW(DENW), .SW(SIDEW)) u_divy (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_v), .in_num(c_ny), .in_den(c_den), .in_side(c_s),
    .out_valid(qy_v), .out_quo(qy), .out_side(qy_side)
  );
  side_t q_s;
  assign q_s = side_t'(qy_side);

  // Stage D: velocity update. Quotient fits well under 24 bits.
  logic                 d_v;
  pai_in_t              d_it;
  logic signed [QW-1:0] d_vx, d_vy;
  logic signed [35:0]   ix, iy;
  always_comb begin
    ix = '0;
    iy = '0;
    if (q_s.it.apply_impulse) begin
      ix = q_s.dx[DW-1] ? -$signed({1'b0, 35'(qx)}) : $signed({1'b0, 35'(qx)});
      iy = q_s.dy[DW-1] ? -$signed({1'b0, 35'(qy)}) : $signed({1'b0, 35'(qy)});
    end
  end
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= qy_v;
    if (en) begin
      d_it <= q_s.it;
      d_vx <= sat24(36'(q_s.it.vel_x) + ix);
      d_vy <= sat24(36'(q_s.it.vel_y) + iy);
    end
  end

  // Stage E: |v|*dt + 500 (34 bits max 8388608*1023+500).
  localparam int unsigned PW = 34;
  logic                 e_v;
  pai_in_t              e_it;
  logic signed [QW-1:0] e_vx, e_vy;
  logic [PW-1:0]        e_px, e_py;
  logic [QW-1:0]        mvx, mvy;
  assign mvx = d_vx[QW-1] ? QW'(-d_vx) : d_vx;
  assign mvy = d_vy[QW-1] ? QW'(-d_vy) : d_vy;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (en) e_v <= d_v;
    if (en) begin
      e_it <= d_it;
      e_vx <= d_vx;
      e_vy <= d_vy;
      e_px <= PW'(mvx) * PW'(d_it.dt_ms) + PW'(MS_PER_S >> 1);
      e_py <= PW'(mvy) * PW'(d_it.dt_ms) + PW'(MS_PER_S >> 1);
    end
  end

  // Stage F: divide by 1000 via reciprocal: floor(p/8) * ceil(2^32/125) >> 32
  // lands on the quotient or one above it; correct in stage G.
  localparam logic [25:0] RECIP = 26'd34359739;   // ceil(2^32/125)
  localparam int unsigned EW = PW - 3;
  logic                 f_v;
  pai_in_t              f_it;
  logic signed [QW-1:0] f_vx, f_vy;
  logic [PW-1:0]        f_px, f_py;
  logic [EW-1:0]        f_qx, f_qy;
  logic [EW+25:0]       mx, my;
  assign mx = e_px[PW-1:3] * RECIP;
  assign my = e_py[PW-1:3] * RECIP;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= e_v;
    if (en) begin
      f_it <= e_it;
      f_vx <= e_vx;
      f_vy <= e_vy;
      f_px <= e_px;
      f_py <= e_py;
      f_qx <= EW'(mx >> 32);
      f_qy <= EW'(my >> 32);
    end
  end

  // Stage G: correct quotient, apply sign, add to position, saturate.
  function automatic logic [EW-1:0] fix_q(input logic [EW-1:0] q,
                                         input logic [PW-1:0] p);
    logic [PW+9:0] prod;
    prod = (PW+10)'(q) * (PW+10)'(MS_PER_S);
    if (prod > (PW+10)'(p)) return q - 1'b1;
    if ((PW+10)'(p) - prod >= (PW+10)'(MS_PER_S)) return q + 1'b1;
    return q;
  endfunction

  logic [EW-1:0]      sx, sy;
  logic signed [35:0] stx, sty;
  assign sx = fix_q(f_qx, f_px);
  assign sy = fix_q(f_qy, f_py);
  assign stx = f_vx[QW-1] ? -$signed(36'(sx)) : $signed(36'(sx));
  assign sty = f_vy[QW-1] ? -$signed(36'(sy)) : $signed(36'(sy));

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= f_v;
    if (en) begin
      out_ch.data.new_pos_x <= sat24(36'(f_it.pos_x) + stx);
      out_ch.data.new_pos_y <= sat24(36'(f_it.pos_y) + sty);
      out_ch.data.new_vel_x <= f_vx;
      out_ch.data.new_vel_y <= f_vy;
      out_ch.data.frame_done <= f_it.last_particle;
    end
  end

`ifndef SYNTH
  a_dx_lockstep: assert property (@(posedge clk) disable iff (rst)
    qx_v == qy_v) else $error("divider lanes out of step");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid) else $error("ready low with empty output");
  a_den: assert property (@(posedge clk) disable iff (rst)
    c_v |-> c_den != '0) else $error("zero divisor");
`endif
endmodule

// ===== sv/pai_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage, with sideband.
// Depends on pai_pkg.
module pai_sqrt #(
  parameter int unsigned SW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [pai_pkg::SQW-1:0]     in_rad,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [pai_pkg::RW-1:0]      out_root,
  output logic [SW-1:0]               out_side
);
  import pai_pkg::*;

  localparam int unsigned N = RW;

  logic [N:0]             v;
  logic [SQW-1:0]         rem [N+1];
  logic [RW-1:0]          root [N+1];
  logic [SW-1:0]          side [N+1];

  assign v[0] = in_valid;
  assign rem[0] = in_rad;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_st
    localparam int unsigned SH = 2 * (N - 1 - i);
    logic [SQW+1:0] trial;
    logic [SQW+1:0] cur;
    always_comb begin
      cur = {2'b0, rem[i]} >> SH;
      trial = {{(SQW+2-RW-2){1'b0}}, root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        side[i+1] <= side[i];
        if (cur >= trial) begin
          rem[i+1] <= rem[i] - SQW'(trial << SH);
          root[i+1] <= {root[i][RW-2:0], 1'b1};
        end else begin
          rem[i+1] <= rem[i];
          root[i+1] <= {root[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_root = root[N];
  assign out_side = side[N];
endmodule

// ===== sv/pai_div.sv =====
// Pipelined restoring divider (unsigned), one quotient bit per stage.
// Depends on pai_pkg.
module pai_div #(
  parameter int unsigned NW = 37,
  parameter int unsigned DNW = 26,
  parameter int unsigned SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [NW-1:0]   in_num,
  input  logic [DNW-1:0]  in_den,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [NW-1:0]   out_quo,
  output logic [SW-1:0]   out_side
);
  import pai_pkg::*;

  logic [NW:0]      v;
  logic [DNW-1:0]   rem [NW+1];
  logic [NW-1:0]    num [NW+1];
  logic [DNW-1:0]   den [NW+1];
  logic [SW-1:0]    side [NW+1];

  assign v[0] = in_valid;
  assign rem[0] = '0;
  assign num[0] = in_num;
  assign den[0] = in_den;
  assign side[0] = in_side;

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DNW:0] shl;
    assign shl = {rem[i], num[i][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        side[i+1] <= side[i];
        den[i+1] <= den[i];
        if (shl >= {1'b0, den[i]}) begin
          rem[i+1] <= DNW'(shl - {1'b0, den[i]});
          num[i+1] <= {num[i][NW-2:0], 1'b1};
        end else begin
          rem[i+1] <= shl[DNW-1:0];
          num[i+1] <= {num[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[NW];
  assign out_quo = num[NW];
  assign out_side = side[NW];
endmodule
